// ===== rtl/core/rnsl_pkg.sv =====
// Shared constants and controller/datapath interface types for the nearest swarm lookup.
package rnsl_pkg;

  localparam int COUNT_W = 9;
  localparam int SLOT_W = 8;
  localparam int WORD_W = 64;
  localparam int DEFAULT_MAX_SWARMS = 256;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic query_start;
    logic step_issue;
    logic step_update;
    logic issue_right;
    logic issue_left;
    logic deliver;
    logic deliver_empty;
  } dp_cmd_t;

  typedef struct packed {
    logic is_query;
    logic count_zero;
    logic search_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/core/rnsl_ctrl.sv =====
// Controller state machine that sequences the binary search and neighbor reads.
module rnsl_ctrl import rnsl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_COMPARE = 3'd2;
  localparam logic [2:0] S_READ_LEFT = 3'd3;
  localparam logic [2:0] S_PICK = 3'd4;
  localparam logic [2:0] S_EMPTY = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && status.is_query) begin
          cmd.query_start = 1'b1;
          state_next = status.count_zero ? S_EMPTY : S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (status.search_done) begin
          cmd.issue_right = 1'b1;
          state_next = S_READ_LEFT;
        end else begin
          cmd.step_issue = 1'b1;
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd.step_update = 1'b1;
        state_next = S_SEARCH;
      end
      S_READ_LEFT: begin
        cmd.issue_left = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        if (status.out_free) begin
          cmd.deliver = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMPTY: begin
        if (status.out_free) begin
          cmd.deliver_empty = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/rnsl_datapath.sv =====
// Datapath with the swarm table memory, search bounds, distance compare and result register.
module rnsl_datapath import rnsl_pkg::*; #(
  parameter int MAX_SWARMS = DEFAULT_MAX_SWARMS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                command,
  input  logic [SLOT_W-1:0]   entry_index,
  input  logic [WORD_W-1:0]   entry_swarm_id,
  input  logic [WORD_W-1:0]   key_word_0,
  input  logic [WORD_W-1:0]   key_word_1,
  input  logic [WORD_W-1:0]   key_word_2,
  input  logic [WORD_W-1:0]   key_word_3,
  input  dp_cmd_t             cmd,
  output dp_status_t          status,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   swarm_index,
  output logic [WORD_W-1:0]   swarm_value,
  output logic [WORD_W-1:0]   key_position,
  output logic                table_empty
);

  localparam int IDX_W = (MAX_SWARMS > 1) ? $clog2(MAX_SWARMS) : 1;
  localparam logic [16:0] MAX_WIDE = 17'(MAX_SWARMS);

  logic [WORD_W-1:0] mem [MAX_SWARMS];
  logic [WORD_W-1:0] rd_data;
  logic [IDX_W-1:0] rd_addr;
  logic rd_en;
  logic wr_en;

  logic [COUNT_W-1:0] swarm_count;
  logic [COUNT_W-1:0] eff_count;
  logic [COUNT_W-1:0] n;
  logic [COUNT_W-1:0] lo;
  logic [COUNT_W-1:0] hi;
  logic [COUNT_W-1:0] mid;
  logic [COUNT_W-1:0] mid_reg;
  logic [COUNT_W:0] mid_sum;
  logic [COUNT_W-1:0] right_sel;
  logic [COUNT_W-1:0] right_reg;
  logic [COUNT_W-1:0] left_reg;
  logic [WORD_W-1:0] pos;
  logic [WORD_W-1:0] right_val;
  logic [WORD_W-1:0] dist_right;
  logic [WORD_W-1:0] dist_left;
  logic pick_right;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swarm_count <= '0;
    end else if (cfg_valid) begin
      swarm_count <= cfg_data;
    end
  end

  assign eff_count = ({8'd0, swarm_count} > MAX_WIDE) ? COUNT_W'(MAX_SWARMS) : swarm_count;

  assign wr_en = in_valid && in_ready && (command == CMD_LOAD) &&
                 ({9'd0, entry_index} < MAX_WIDE);

  assign mid_sum = {1'b0, lo} + {1'b0, hi};
  assign mid = mid_sum[COUNT_W:1];
  assign right_sel = (lo == n) ? '0 : lo;

  always_comb begin
    if (cmd.step_issue) begin
      rd_addr = IDX_W'(mid);
    end else if (cmd.issue_right) begin
      rd_addr = IDX_W'(right_sel);
    end else begin
      rd_addr = IDX_W'(left_reg);
    end
  end

  assign rd_en = cmd.step_issue || cmd.issue_right || cmd.issue_left;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[IDX_W'(entry_index)] <= entry_swarm_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n <= '0;
      lo <= '0;
      hi <= '0;
    end else if (cmd.query_start) begin
      n <= eff_count;
      lo <= '0;
      hi <= eff_count;
    end else if (cmd.step_update) begin
      if (rd_data < pos) begin
        lo <= mid_reg + COUNT_W'(1);
      end else begin
        hi <= mid_reg;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      pos <= key_word_0 ^ key_word_1 ^ key_word_2 ^ key_word_3;
    end
    if (cmd.step_issue) begin
      mid_reg <= mid;
    end
    if (cmd.issue_right) begin
      right_reg <= right_sel;
      left_reg <= (right_sel == '0) ? (n - COUNT_W'(1)) : (right_sel - COUNT_W'(1));
    end
    if (cmd.issue_left) begin
      right_val <= rd_data;
    end
  end

  assign dist_right = right_val - pos;
  assign dist_left = pos - rd_data;
  assign pick_right = dist_right < dist_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.deliver || cmd.deliver_empty) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.deliver) begin
      swarm_index <= pick_right ? right_reg[SLOT_W-1:0] : left_reg[SLOT_W-1:0];
      swarm_value <= pick_right ? right_val : rd_data;
      key_position <= pos;
      table_empty <= 1'b0;
    end else if (cmd.deliver_empty) begin
      swarm_index <= '0;
      swarm_value <= '0;
      key_position <= pos;
      table_empty <= 1'b1;
    end
  end

  assign status.is_query = (command == CMD_QUERY);
  assign status.count_zero = (eff_count == '0);
  assign status.search_done = !(lo < hi);
  assign status.out_free = !out_valid || out_ready;

`ifndef SYNTHESIS
  a_bounds_ordered: assert property (@(posedge clk) disable iff (rst)
    (lo <= hi) && (hi <= n))
    else $error("search bounds out of order");

  a_deliver_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.deliver || cmd.deliver_empty) |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_neighbors_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.deliver |-> (right_reg < n) && (left_reg < n))
    else $error("neighbor slot beyond loaded count");
`endif

endmodule

// ===== rtl/core/ring_nearest_swarm_lookup.sv =====
// Top level of the nearest swarm lookup on a 64-bit hash ring.
//
// Three channels, each with valid and ready. The configuration channel writes
// the swarm count (cfg_data) and is always ready. The request channel carries
// a command: a load writes entry_swarm_id into slot entry_index in the cycle
// it is accepted and gives no result; a query folds the four key words into a
// ring position and returns the nearest loaded swarm on the result channel.
// Entries must be loaded in ascending order before they are queried.
// A query walks a binary search over the table memory, each step being one
// registered memory read and then one bound update, then reads both neighbors
// and compares distances. An empty table skips the search and the result
// comes back with table_empty set. The table memory has a single read port,
// so the search reads and the neighbor reads are issued one after another.
// A new request is taken in the cycle after the previous query has moved its
// result into the output register, and a load leaves the block ready for the
// next request; while the receiver stalls, a finished query waits for the
// register and the block takes no new request.
// Reset clears the count and the control state; the table contents are
// undefined until loaded.
module ring_nearest_swarm_lookup import rnsl_pkg::*; #(
  parameter int MAX_SWARMS = DEFAULT_MAX_SWARMS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [COUNT_W-1:0]  cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                command,
  input  logic [SLOT_W-1:0]   entry_index,
  input  logic [WORD_W-1:0]   entry_swarm_id,
  input  logic [WORD_W-1:0]   key_word_0,
  input  logic [WORD_W-1:0]   key_word_1,
  input  logic [WORD_W-1:0]   key_word_2,
  input  logic [WORD_W-1:0]   key_word_3,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [SLOT_W-1:0]   swarm_index,
  output logic [WORD_W-1:0]   swarm_value,
  output logic [WORD_W-1:0]   key_position,
  output logic                table_empty
);

  dp_cmd_t cmd;
  dp_status_t status;

  rnsl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rnsl_datapath #(
    .MAX_SWARMS (MAX_SWARMS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .command        (command),
    .entry_index    (entry_index),
    .entry_swarm_id (entry_swarm_id),
    .key_word_0     (key_word_0),
    .key_word_1     (key_word_1),
    .key_word_2     (key_word_2),
    .key_word_3     (key_word_3),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .swarm_index    (swarm_index),
    .swarm_value    (swarm_value),
    .key_position   (key_position),
    .table_empty    (table_empty)
  );

endmodule
